>>> rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants of the track event parser: parse phases, result
// kinds, error codes, status byte codes and the result record.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int MAX_VLQ_BYTES = 4;
   localparam int VLQ_W         = 28;
   localparam int VLQ_CNT_W     = 3;

   localparam logic [VLQ_CNT_W-1:0] VLQ_CNT_MAX = VLQ_CNT_W'(MAX_VLQ_BYTES);

   localparam logic [1:0] KIND_CHANNEL   = 2'd0;
   localparam logic [1:0] KIND_META_HDR  = 2'd1;
   localparam logic [1:0] KIND_META_DATA = 2'd2;
   localparam logic [1:0] KIND_ERROR     = 2'd3;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_TOO_LONG   = 2'd1;
   localparam logic [1:0] ERR_BAD_STATUS = 2'd2;

   localparam logic [7:0] STATUS_META    = 8'hFF;
   localparam logic [7:0] STATUS_NONE    = 8'h00;
   localparam logic [3:0] NIBBLE_SYSTEM  = 4'hF;
   localparam logic [3:0] NIBBLE_PROGRAM = 4'hC;
   localparam logic [3:0] NIBBLE_PRESS   = 4'hD;

   localparam logic [1:0] COUNT_ONE      = 2'd1;
   localparam logic [1:0] COUNT_TWO      = 2'd2;

   typedef enum logic [6:0] {
      PH_DELTA  = 7'b000_0001,
      PH_STATUS = 7'b000_0010,
      PH_DATA1  = 7'b000_0100,
      PH_DATA2  = 7'b000_1000,
      PH_MTYPE  = 7'b001_0000,
      PH_MLEN   = 7'b010_0000,
      PH_MDATA  = 7'b100_0000
   } phase_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [VLQ_W-1:0] delta_time;
      logic [3:0]       status_nibble;
      logic [3:0]       channel;
      logic [7:0]       data_first;
      logic [7:0]       data_second;
      logic [1:0]       data_count;
      logic [7:0]       meta_type;
      logic [VLQ_W-1:0] meta_length;
      logic             last_of_event;
      logic [1:0]       error_code;
   } result_type;

endpackage

>>> rtl/mtep_core.sv
// ----------------------------------------------------------------------------
// mtep_core
// Parser state and one-byte step: variable-length quantities, status and
// running status, channel data bytes and meta events. Produces at most one
// result per byte.
// ----------------------------------------------------------------------------
module mtep_core
   import mtep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] track_byte,
   input  logic       track_start,
   output logic       result_valid,
   output result_type result
);

   phase_type            phase_ff, phase_in, phase_cur;
   logic [VLQ_W-1:0]     vlq_acc_ff, vlq_acc_in, vlq_acc_cur;
   logic [VLQ_CNT_W-1:0] vlq_cnt_ff, vlq_cnt_in, vlq_cnt_cur;
   logic [VLQ_W-1:0]     held_delta_ff, held_delta_in, held_delta_cur;
   logic [7:0]           run_status_ff, run_status_in, run_status_cur;
   logic [7:0]           held_first_ff, held_first_in, held_first_cur;
   logic [7:0]           held_mtype_ff, held_mtype_in, held_mtype_cur;
   logic [VLQ_W-1:0]     meta_rem_ff, meta_rem_in, meta_rem_cur;

   logic [VLQ_W-1:0]     acc_next;
   logic [VLQ_CNT_W-1:0] cnt_next;
   logic                 vlq_done;
   logic                 vlq_over;
   logic                 one_byte_run;
   logic [VLQ_W-1:0]     rem_dec;

   always_comb begin
      phase_cur      = track_start ? PH_DELTA : phase_ff;
      vlq_acc_cur    = track_start ? '0 : vlq_acc_ff;
      vlq_cnt_cur    = track_start ? '0 : vlq_cnt_ff;
      held_delta_cur = track_start ? '0 : held_delta_ff;
      run_status_cur = track_start ? STATUS_NONE : run_status_ff;
      held_first_cur = track_start ? '0 : held_first_ff;
      held_mtype_cur = track_start ? '0 : held_mtype_ff;
      meta_rem_cur   = track_start ? '0 : meta_rem_ff;
   end

   assign acc_next     = {vlq_acc_cur[VLQ_W-8:0], track_byte[6:0]};
   assign cnt_next     = vlq_cnt_cur + VLQ_CNT_W'(1);
   assign vlq_done     = !track_byte[7];
   assign vlq_over     = track_byte[7] && (cnt_next >= VLQ_CNT_MAX);
   assign one_byte_run = (run_status_cur[7:4] == NIBBLE_PROGRAM)
                      || (run_status_cur[7:4] == NIBBLE_PRESS);
   assign rem_dec      = meta_rem_cur - VLQ_W'(1);

   always_comb begin
      phase_in      = phase_cur;
      vlq_acc_in    = vlq_acc_cur;
      vlq_cnt_in    = vlq_cnt_cur;
      held_delta_in = held_delta_cur;
      run_status_in = run_status_cur;
      held_first_in = held_first_cur;
      held_mtype_in = held_mtype_cur;
      meta_rem_in   = meta_rem_cur;
      result_valid  = 1'b0;
      result        = '0;

      case (phase_cur)
         PH_DELTA: begin
            vlq_acc_in = acc_next;
            vlq_cnt_in = cnt_next;
            if (vlq_done) begin
               held_delta_in = acc_next;
               vlq_acc_in    = '0;
               vlq_cnt_in    = '0;
               phase_in      = PH_STATUS;
            end else if (vlq_over) begin
               result_valid         = 1'b1;
               result.kind          = KIND_ERROR;
               result.last_of_event = 1'b1;
               result.error_code    = ERR_TOO_LONG;
               vlq_acc_in           = '0;
               vlq_cnt_in           = '0;
               phase_in             = PH_DELTA;
            end
         end
         PH_STATUS: begin
            if (track_byte[7]) begin
               if (track_byte == STATUS_META) begin
                  run_status_in = STATUS_NONE;
                  phase_in      = PH_MTYPE;
               end else if (track_byte[7:4] == NIBBLE_SYSTEM) begin
                  run_status_in        = STATUS_NONE;
                  result_valid         = 1'b1;
                  result.kind          = KIND_ERROR;
                  result.delta_time    = held_delta_cur;
                  result.last_of_event = 1'b1;
                  result.error_code    = ERR_BAD_STATUS;
                  vlq_acc_in           = '0;
                  vlq_cnt_in           = '0;
                  phase_in             = PH_DELTA;
               end else begin
                  run_status_in = track_byte;
                  phase_in      = PH_DATA1;
               end
            end else if (run_status_cur == STATUS_NONE) begin
               result_valid         = 1'b1;
               result.kind          = KIND_ERROR;
               result.delta_time    = held_delta_cur;
               result.last_of_event = 1'b1;
               result.error_code    = ERR_BAD_STATUS;
               vlq_acc_in           = '0;
               vlq_cnt_in           = '0;
               phase_in             = PH_DELTA;
            end else begin
               held_first_in = track_byte;
               if (one_byte_run) begin
                  result_valid         = 1'b1;
                  result.kind          = KIND_CHANNEL;
                  result.delta_time    = held_delta_cur;
                  result.status_nibble = run_status_cur[7:4];
                  result.channel       = run_status_cur[3:0];
                  result.data_first    = track_byte;
                  result.data_count    = COUNT_ONE;
                  result.last_of_event = 1'b1;
                  vlq_acc_in           = '0;
                  vlq_cnt_in           = '0;
                  phase_in             = PH_DELTA;
               end else begin
                  phase_in = PH_DATA2;
               end
            end
         end
         PH_DATA1: begin
            held_first_in = track_byte;
            if (one_byte_run) begin
               result_valid         = 1'b1;
               result.kind          = KIND_CHANNEL;
               result.delta_time    = held_delta_cur;
               result.status_nibble = run_status_cur[7:4];
               result.channel       = run_status_cur[3:0];
               result.data_first    = track_byte;
               result.data_count    = COUNT_ONE;
               result.last_of_event = 1'b1;
               vlq_acc_in           = '0;
               vlq_cnt_in           = '0;
               phase_in             = PH_DELTA;
            end else begin
               phase_in = PH_DATA2;
            end
         end
         PH_DATA2: begin
            result_valid         = 1'b1;
            result.kind          = KIND_CHANNEL;
            result.delta_time    = held_delta_cur;
            result.status_nibble = run_status_cur[7:4];
            result.channel       = run_status_cur[3:0];
            result.data_first    = held_first_cur;
            result.data_second   = track_byte;
            result.data_count    = COUNT_TWO;
            result.last_of_event = 1'b1;
            vlq_acc_in           = '0;
            vlq_cnt_in           = '0;
            phase_in             = PH_DELTA;
         end
         PH_MTYPE: begin
            held_mtype_in = track_byte;
            vlq_acc_in    = '0;
            vlq_cnt_in    = '0;
            phase_in      = PH_MLEN;
         end
         PH_MLEN: begin
            vlq_acc_in = acc_next;
            vlq_cnt_in = cnt_next;
            if (vlq_done) begin
               meta_rem_in          = acc_next;
               result_valid         = 1'b1;
               result.kind          = KIND_META_HDR;
               result.delta_time    = held_delta_cur;
               result.meta_type     = held_mtype_cur;
               result.meta_length   = acc_next;
               result.last_of_event = (acc_next == '0);
               vlq_acc_in           = '0;
               vlq_cnt_in           = '0;
               phase_in             = (acc_next == '0) ? PH_DELTA : PH_MDATA;
            end else if (vlq_over) begin
               result_valid         = 1'b1;
               result.kind          = KIND_ERROR;
               result.delta_time    = held_delta_cur;
               result.last_of_event = 1'b1;
               result.error_code    = ERR_TOO_LONG;
               vlq_acc_in           = '0;
               vlq_cnt_in           = '0;
               phase_in             = PH_DELTA;
            end
         end
         PH_MDATA: begin
            meta_rem_in       = rem_dec;
            result_valid      = 1'b1;
            result.kind       = KIND_META_DATA;
            result.delta_time = held_delta_cur;
            result.data_first = track_byte;
            result.meta_type  = held_mtype_cur;
            if (rem_dec == '0) begin
               result.last_of_event = 1'b1;
               vlq_acc_in           = '0;
               vlq_cnt_in           = '0;
               phase_in             = PH_DELTA;
            end
         end
         default: begin
            vlq_acc_in = '0;
            vlq_cnt_in = '0;
            phase_in   = PH_DELTA;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DELTA;
         vlq_acc_ff    <= '0;
         vlq_cnt_ff    <= '0;
         held_delta_ff <= '0;
         run_status_ff <= STATUS_NONE;
         held_first_ff <= '0;
         held_mtype_ff <= '0;
         meta_rem_ff   <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         vlq_acc_ff    <= vlq_acc_in;
         vlq_cnt_ff    <= vlq_cnt_in;
         held_delta_ff <= held_delta_in;
         run_status_ff <= run_status_in;
         held_first_ff <= held_first_in;
         held_mtype_ff <= held_mtype_in;
         meta_rem_ff   <= meta_rem_in;
      end
   end

endmodule

>>> rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Byte-serial parser for the body of a Standard MIDI File track chunk.
//
// req channel: one track byte per transaction; req_tuser marks the first
// byte of a track and clears running status and all parser state.
// rsp channel: zero or one result per input byte (channel event, meta
// header, meta payload byte or error); rsp_tlast marks the final result of
// an event and rsp_tuser carries the result kind.
// Path: a byte is registered in the input register on acceptance, then
// parsed into the result register, which drives rsp_tvalid.
// Throughput: one byte per cycle while no result is held or rsp_tready is
// high; the parser step updates the phase and quantity registers.
// Stall: while rsp_tready is low and a result is held, one more byte waits
// in the input register and req_tready drops; nothing is lost.
// Reset: synchronous, clears both registers' valid flags and returns the
// parser to expecting a delta time with no running status.
// ----------------------------------------------------------------------------
module midi_track_event_parser
   import mtep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // track_byte
   input  logic        req_tuser,  // track_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // delta_time, status_nibble, channel, data_first, data_second,
   // data_count, meta_type, meta_length, error_code, zero pad
   output logic [95:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,  // kind
   output logic        rsp_tlast   // last_of_event
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       step;
   logic       res_valid;
   result_type res;

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   mtep_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step),
      .track_byte   (in_byte_ff),
      .track_start  (in_start_ff),
      .result_valid (res_valid),
      .result       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= res_valid;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last_of_event;
   assign rsp_tdata  = {4'b0000,
                        out_ff.error_code,
                        out_ff.meta_length,
                        out_ff.meta_type,
                        out_ff.data_count,
                        out_ff.data_second,
                        out_ff.data_first,
                        out_ff.channel,
                        out_ff.status_nibble,
                        out_ff.delta_time};

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte dropped while stalled");

   a_error_ends_event: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_ERROR) |-> rsp_tlast)
      else $error("error result without last mark");

   a_error_code_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_ERROR) == (out_ff.error_code != ERR_NONE)))
      else $error("error code does not match result kind");

   a_channel_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_CHANNEL)
         |-> (out_ff.data_count != 2'd0) && out_ff.status_nibble[3] && rsp_tlast)
      else $error("malformed channel event");

endmodule
